@@ src/bah_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bah_pkg;
	localparam int BINS       = 1024;
	localparam int BOND_SLOTS = 16;

	localparam int COS_W   = 17;
	localparam int SLOT_W  = 4;
	localparam int IDX_W   = 10;
	localparam int CNT_W   = 32;
	localparam int COS_ONE = 32768;

	localparam int BIN_W   = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int SLOT_AW = (BOND_SLOTS > 1) ? $clog2(BOND_SLOTS) : 1;
	localparam int ADDR_W  = SLOT_AW + BIN_W;
	localparam int DEPTH   = 2 ** ADDR_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef enum logic {
		CMD_ADD  = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;
endpackage
`default_nettype wire

@@ src/bah_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bah_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

@@ src/bah_bin_map.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bah_bin_map (
	input  wire logic signed [bah_pkg::COS_W-1:0] cosine_value,
	output logic             [bah_pkg::BIN_W-1:0] bin
);
	import bah_pkg::*;

	localparam logic [COS_W:0] BINS_V = (COS_W + 1)'(BINS);
	localparam logic signed [COS_W:0] ONE_V = (COS_W + 1)'(COS_ONE);

	logic signed [COS_W:0]   offset;
	logic [2*COS_W+1:0]      prod;
	logic [2*COS_W-15:0]     scaled;

	// bin = floor((c + 1.0) * BINS / 2), clamped at both ends
	always_comb begin
		offset = $signed({cosine_value[COS_W-1], cosine_value}) + ONE_V;
		prod   = (2*COS_W+2)'(offset[COS_W-1:0]) * (2*COS_W+2)'(BINS_V);
		scaled = prod[2*COS_W+1:16];
		if (offset[COS_W]) begin
			bin = '0;
		end else if (32'(scaled) >= BINS) begin
			bin = BIN_W'(BINS - 1);
		end else begin
			bin = scaled[BIN_W-1:0];
		end
	end
endmodule
`default_nettype wire

@@ src/bond_angle_histogram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// done is registered from valid_s1, which is set at the accepting edge; bin_index and bin_count are registered with it
// throughput: one transaction per cycle while busy is low, read-modify-write on one ram with write forwarding
// reset: busy stays high after arst_n releases while every entry of the count ram is
// cleared, one entry a cycle; no transaction is accepted during that pass
// the receiver cannot stall: each result is shown for exactly one cycle with done high
module bond_angle_histogram (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              command,
	input  wire logic        [bah_pkg::SLOT_W-1:0] bond_slot,
	input  wire logic signed [bah_pkg::COS_W-1:0]  cosine_value,
	input  wire logic        [bah_pkg::IDX_W-1:0]  read_bin,
	output logic                                   done,
	output logic             [bah_pkg::IDX_W-1:0]  bin_index,
	output logic             [bah_pkg::CNT_W-1:0]  bin_count
);
	import bah_pkg::*;

	logic              clearing_q;
	logic [ADDR_W:0]   clr_cnt_q;

	logic              accept;
	logic [BIN_W-1:0]  cos_bin;
	logic [BIN_W-1:0]  sel_bin;
	logic [ADDR_W-1:0] rd_addr;
	logic [CNT_W-1:0]  ram_q;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              slot_ok_s1;
	logic              bin_ok_s1;

	logic              wr_valid_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [CNT_W-1:0]  wr_data_q;

	logic [CNT_W-1:0]  cur;
	logic [CNT_W-1:0]  inc;
	logic [CNT_W-1:0]  res;
	logic              upd;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CNT_W-1:0]  ram_wdata;

	assign busy   = clearing_q;
	assign accept = start && !busy;

	bah_bin_map u_bin_map (
		.cosine_value (cosine_value),
		.bin          (cos_bin)
	);

	always_comb begin
		sel_bin = (cmd_t'(command) == CMD_READ) ? BIN_W'(read_bin) : cos_bin;
		rd_addr = {bond_slot[SLOT_AW-1:0], sel_bin};
	end

	// stage 1: read data arrives, forward the write made in the previous cycle; zeros are written while clearing
	always_comb begin
		cur = (wr_valid_q && wr_addr_q == addr_s1) ? wr_data_q : ram_q;
		inc = (cur == COUNT_MAX) ? cur : cur + CNT_W'(1);
		upd = valid_s1 && cmd_s1 == CMD_ADD && slot_ok_s1;
		unique case (cmd_s1)
			CMD_ADD:  res = slot_ok_s1 ? inc : '0;
			CMD_READ: res = (slot_ok_s1 && bin_ok_s1) ? cur : '0;
			default:  res = '0;
		endcase
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q[ADDR_W-1:0];
			ram_wdata = '0;
		end else begin
			ram_we    = upd;
			ram_waddr = addr_s1;
			ram_wdata = inc;
		end
	end

	bah_ram #(
		.WIDTH (CNT_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			valid_s1   <= 1'b0;
			wr_valid_q <= 1'b0;
			done       <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + (ADDR_W + 1)'(1);
				if (clr_cnt_q == (ADDR_W + 1)'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			valid_s1   <= accept;
			wr_valid_q <= upd;
			done       <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd_t'(command);
			addr_s1    <= rd_addr;
			idx_s1     <= (cmd_t'(command) == CMD_READ) ? read_bin : IDX_W'(cos_bin);
			slot_ok_s1 <= 32'(bond_slot) < BOND_SLOTS;
			bin_ok_s1  <= 32'(read_bin) < BINS;
		end
		wr_addr_q <= addr_s1;
		wr_data_q <= inc;
		if (valid_s1) begin
			bin_index <= idx_s1;
			bin_count <= res;
		end
	end
endmodule
`default_nettype wire
